// ----- rtl/imv_pkg.sv -----
package imv_pkg;

  // Field widths fixed by the word formats on the ports.
  localparam int SAMPLE_FIELD_W = 16;
  localparam int MEAN_W         = 16;
  localparam int VAR_W          = 32;
  localparam int COUNT_FIELD_W  = 13;

  // Defaults for the top-level parameters.
  localparam int DEFAULT_MAX_SAMPLES = 4096;
  localparam int DEFAULT_SAMPLE_BITS = 16;

  typedef struct packed {
    logic signed [SAMPLE_FIELD_W-1:0] sample;
    logic                             last;
  } samp_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0]   mean;
    logic [VAR_W-1:0]           variance;
    logic [COUNT_FIELD_W-1:0]   sample_count;
    logic                       overflow;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_stage;
    logic accum;
    logic div_load_mean;
    logic div_load_var;
    logic div_step;
    logic mul_load;
    logic mul_step;
    logic result_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic res_free;
  } dp_status_t;

endpackage

// ----- rtl/imv_ctrl.sv -----
module imv_ctrl
  import imv_pkg::*;
#(
  parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES,
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       samp_valid,
  input  logic       samp_last,
  output logic       samp_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int DIV_W  = 2 * SAMPLE_BITS - 1 + CNT_W;
  localparam int STEP_W = $clog2(DIV_W);

  typedef enum logic [3:0] {
    S_ACC,
    S_FLUSH,
    S_MEAN_INIT,
    S_MEAN_DIV,
    S_MUL_INIT,
    S_MUL,
    S_VAR_INIT,
    S_VAR_DIV,
    S_DONE
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              stage_vld;

  logic div_last;
  logic mul_last;

  assign div_last   = (step == STEP_W'(DIV_W - 1));
  assign mul_last   = (step == STEP_W'(SAMPLE_BITS - 1));
  assign samp_ready = (state == S_ACC);

  always_comb begin
    cmd               = '0;
    cmd.accum         = stage_vld;
    cmd.load_stage    = (state == S_ACC) && samp_valid;
    cmd.div_load_mean = (state == S_MEAN_INIT);
    cmd.div_load_var  = (state == S_VAR_INIT);
    cmd.div_step      = (state == S_MEAN_DIV) || (state == S_VAR_DIV);
    cmd.mul_load      = (state == S_MUL_INIT);
    cmd.mul_step      = (state == S_MUL);
    cmd.result_load   = (state == S_DONE) && status.res_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACC;
      step      <= '0;
      stage_vld <= 1'b0;
    end else begin
      stage_vld <= (state == S_ACC) && samp_valid;
      unique case (state)
        S_ACC: begin
          if (samp_valid && samp_last) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state <= S_MEAN_INIT;
        end
        S_MEAN_INIT: begin
          step  <= '0;
          state <= S_MEAN_DIV;
        end
        S_MEAN_DIV: begin
          step <= step + 1'b1;
          if (div_last) begin
            state <= S_MUL_INIT;
          end
        end
        S_MUL_INIT: begin
          step  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          step <= step + 1'b1;
          if (mul_last) begin
            state <= S_VAR_INIT;
          end
        end
        S_VAR_INIT: begin
          step  <= '0;
          state <= S_VAR_DIV;
        end
        S_VAR_DIV: begin
          step <= step + 1'b1;
          if (div_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (status.res_free) begin
            state <= S_ACC;
          end
        end
        default: begin
          state <= S_ACC;
        end
      endcase
    end
  end

endmodule

// ----- rtl/imv_datapath.sv -----
module imv_datapath
  import imv_pkg::*;
#(
  parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES,
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  samp_t      samp,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int SQ_W  = 2 * SAMPLE_BITS - 1 + CNT_W;
  localparam int DIV_W = SQ_W;
  localparam int ADD_W = SUM_W + 1;
  localparam int RAW_W = (SAMPLE_BITS > SAMPLE_FIELD_W) ? SAMPLE_BITS : SAMPLE_FIELD_W;
  localparam int QX_W  = (DIV_W > VAR_W) ? DIV_W : VAR_W + 1;
  localparam int NX_W  = (CNT_W > COUNT_FIELD_W) ? CNT_W : COUNT_FIELD_W + 1;

  // Input stage: the sample is narrowed to SAMPLE_BITS and squared.
  logic [RAW_W-1:0]         raw;
  logic [SAMPLE_BITS-1:0]   s_bits;
  logic [SAMPLE_BITS-1:0]   s_mag;
  logic [2*SAMPLE_BITS-1:0] s_sq;

  logic signed [SAMPLE_BITS-1:0] stg_s;
  logic [2*SAMPLE_BITS-1:0]      stg_sq;

  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] running_sum;
  logic [SQ_W-1:0]         running_square_sum;
  logic                    too_many;

  logic             sum_neg;
  logic [SUM_W-1:0] sum_mag;

  // Shared restoring divider, one quotient bit per cycle.
  logic [DIV_W-1:0] dq;
  logic [CNT_W-1:0] drem;
  logic [CNT_W:0]   trial;
  logic             trial_ge;

  // Shift-add multiplier for |mean| * (|sum| + |remainder|).
  logic [SAMPLE_BITS-1:0] mean_mag;
  logic [SAMPLE_BITS-1:0] mpl;
  logic [SQ_W-1:0]        mcand;
  logic [SQ_W-1:0]        prod;

  logic [MEAN_W-1:0] q16;
  logic [QX_W-1:0]   qx;
  logic [NX_W-1:0]   nx;

  assign raw    = RAW_W'($unsigned(samp.sample));
  assign s_bits = raw[SAMPLE_BITS-1:0];
  assign s_mag  = s_bits[SAMPLE_BITS-1] ? (~s_bits + 1'b1) : s_bits;
  assign s_sq   = {{SAMPLE_BITS{1'b0}}, s_mag} * {{SAMPLE_BITS{1'b0}}, s_mag};

  assign sum_neg = running_sum[SUM_W-1];
  assign sum_mag = sum_neg ? $unsigned(-running_sum) : $unsigned(running_sum);

  assign trial    = {drem, dq[DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, count});

  assign q16 = MEAN_W'(mean_mag);
  assign qx  = QX_W'(dq);
  assign nx  = NX_W'(count);

  assign status.res_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_stage) begin
      stg_s  <= signed'(s_bits);
      stg_sq <= s_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count              <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      too_many           <= 1'b0;
    end else if (cmd.result_load) begin
      count              <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      too_many           <= 1'b0;
    end else if (cmd.accum) begin
      if (count < CNT_W'(MAX_SAMPLES)) begin
        count              <= count + 1'b1;
        running_sum        <= running_sum + SUM_W'(stg_s);
        running_square_sum <= running_square_sum + SQ_W'(stg_sq);
      end else begin
        too_many <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load_mean) begin
      dq   <= DIV_W'(sum_mag);
      drem <= '0;
    end else if (cmd.div_load_var) begin
      dq   <= running_square_sum - prod;
      drem <= '0;
    end else if (cmd.div_step) begin
      dq   <= {dq[DIV_W-2:0], trial_ge};
      drem <= trial_ge ? CNT_W'(trial - {1'b0, count}) : trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mean_mag <= SAMPLE_BITS'(dq);
      mpl      <= SAMPLE_BITS'(dq);
      mcand    <= SQ_W'({1'b0, sum_mag} + ADD_W'(drem));
      prod     <= '0;
    end else if (cmd.mul_step) begin
      if (mpl[0]) begin
        prod <= prod + mcand;
      end
      mcand <= mcand << 1;
      mpl   <= mpl >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.result_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      res.mean         <= signed'(sum_neg ? (~q16 + 1'b1) : q16);
      res.variance     <= (|qx[QX_W-1:VAR_W]) ? '1 : qx[VAR_W-1:0];
      res.sample_count <= (|nx[NX_W-1:COUNT_FIELD_W]) ? '1 : nx[COUNT_FIELD_W-1:0];
      res.overflow     <= too_many;
    end
  end

endmodule

// ----- rtl/integer_mean_and_variance.sv -----
// Integer mean and variance of a set of signed samples.
//
// Input channel samp (samp_valid/samp_ready) carries one sample word per
// cycle. The word whose last bit is set closes the set. Output channel res
// (res_valid/res_ready) carries one result word per set: the mean truncated
// toward zero, the variance truncated and saturated to 32 bits, the sample
// count saturated to 13 bits, and an overflow flag when more than
// MAX_SAMPLES samples arrived (extra samples are dropped from the sums).
//
// While a set is being collected, one sample is taken every cycle. After the
// last sample the block stops taking words and runs a shared bit-serial
// divider twice (|sum| / count, then the exact squared deviation sum /
// count) with a shift-add multiplier in between. The divider is DIV_W bits
// wide, where DIV_W = 2*SAMPLE_BITS - 1 + clog2(MAX_SAMPLES+1). samp_ready
// drops after the last sample and returns with res_valid. While the receiver
// stalls the output register holds its word; a finished result then waits in
// the controller and no sample is taken until it moves.
// Reset clears the sums, the count, the overflow flag and the output valid.
module integer_mean_and_variance
  import imv_pkg::*;
#(
  parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES,
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  samp_valid,
  output logic  samp_ready,
  input  samp_t samp,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller sequences accumulation, the two divisions and the
  // multiply; of the datapath it only sees the output register's free flag.
  imv_ctrl #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .samp_valid(samp_valid),
    .samp_last (samp.last),
    .samp_ready(samp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the sums, the divider, the multiplier and the
  // output register.
  imv_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .samp     (samp),
    .cmd      (cmd),
    .status   (status),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

endmodule

// ----- rtl/imv_checker.sv -----
module imv_checker
  import imv_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  samp_valid,
  input logic  samp_ready,
  input samp_t samp,
  input logic  res_valid,
  input logic  res_ready,
  input res_t  res
);

  // A stalled result word holds still.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  // Closing a set starts the computation, so no word is taken next cycle.
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    samp_valid && samp_ready && samp.last |=> !samp_ready)
    else $error("sample taken right after the last word of a set");

  // Every result covers at least one sample.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.sample_count != '0)
    else $error("result with zero sample count");

  // Reset empties the output and opens the input.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !res_valid && samp_ready)
    else $error("wrong state after reset");

endmodule

bind integer_mean_and_variance imv_checker u_imv_checker (
  .clk       (clk),
  .rst       (rst),
  .samp_valid(samp_valid),
  .samp_ready(samp_ready),
  .samp      (samp),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

// ----- tb/tb.sv -----
module tb;
  import imv_pkg::*;

  localparam int MAX_SAMPLES = DEFAULT_MAX_SAMPLES;
  localparam int SAMPLE_BITS = DEFAULT_SAMPLE_BITS;

  // Delay from the last word of a set to its result word; SETTLE_CYCLES adds slack on top.
  localparam int RESULT_LATENCY = 2 * (2 * SAMPLE_BITS - 1 + $clog2(MAX_SAMPLES + 1))
                                  + SAMPLE_BITS + 5;
  localparam int SETTLE_CYCLES  = RESULT_LATENCY + 40;

  // The receiver holds off this long once, so that results pile up and the input stalls.
  localparam int HOLD_OFF_CYCLES = 600;

  localparam int RANDOM_ITEMS = 750;

  // Tracks the running statistics of the set being collected and keeps the result
  // words that the block still owes, oldest first.
  class mean_var_tracker;
    int unsigned       set_count;
    longint            set_sum;
    longint unsigned   set_square_sum;
    bit                set_dropped;
    res_t              owed_results[$];
    int                errors;
    int                words_taken;
    int                results_checked;
    int                overflow_results;

    function new();
      set_count      = 0;
      set_sum        = 0;
      set_square_sum = 0;
      set_dropped    = 1'b0;
      errors         = 0;
      words_taken    = 0;
      results_checked = 0;
      overflow_results = 0;
    endfunction

    // Called for every sample word that the block accepts.
    function void note_word(samp_t w);
      longint          s;
      longint unsigned mag;
      longint unsigned q;
      longint unsigned n;
      longint unsigned dev_sum;
      longint unsigned var_q;
      longint unsigned um;
      longint unsigned us;
      longint          m;
      res_t            r;
      words_taken++;
      // Only the low SAMPLE_BITS bits count, as two's complement.
      s = longint'(w.sample);
      s = (s <<< (64 - SAMPLE_BITS)) >>> (64 - SAMPLE_BITS);
      if (set_count < MAX_SAMPLES) begin
        mag = (s < 0) ? longint'(-s) : s;
        set_count++;
        set_sum        += s;
        set_square_sum += mag * mag;
      end else begin
        set_dropped = 1'b1;
      end
      if (!w.last) return;

      n   = set_count;
      mag = (set_sum < 0) ? longint'(-set_sum) : set_sum;
      q   = mag / n;
      m   = (set_sum < 0) ? -longint'(q) : longint'(q);
      // Sum of squared deviations from the truncated mean. Wrapping 64-bit
      // arithmetic lands on the exact value since the true result is small.
      um = m;
      us = set_sum;
      dev_sum = set_square_sum - 64'd2 * um * us + n * um * um;
      var_q   = dev_sum / n;
      if (var_q > 64'hFFFF_FFFF) var_q = 64'hFFFF_FFFF;

      r.mean         = m[MEAN_W-1:0];
      r.variance     = var_q[VAR_W-1:0];
      r.sample_count = (n > 64'd8191) ? 13'd8191 : n[COUNT_FIELD_W-1:0];
      r.overflow     = set_dropped;
      owed_results.push_back(r);

      set_count      = 0;
      set_sum        = 0;
      set_square_sum = 0;
      set_dropped    = 1'b0;
    endfunction

    // Called for every result word that the receiver accepts.
    function void check_result(res_t got);
      res_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: result word with no set owed: mean %0d variance %0d count %0d ovf %0b",
                 $time, got.mean, got.variance, got.sample_count, got.overflow);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      results_checked++;
      if (want.overflow) overflow_results++;
      if (got.mean !== want.mean) begin
        $display("%0t: mean mismatch: expected %0d, actual %0d", $time, want.mean, got.mean);
        errors++;
      end
      if (got.variance !== want.variance) begin
        $display("%0t: variance mismatch: expected %0d, actual %0d",
                 $time, want.variance, got.variance);
        errors++;
      end
      if (got.sample_count !== want.sample_count) begin
        $display("%0t: sample_count mismatch: expected %0d, actual %0d",
                 $time, want.sample_count, got.sample_count);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow mismatch: expected %0b, actual %0b",
                 $time, want.overflow, got.overflow);
        errors++;
      end
    endfunction

    function int owed();
      return owed_results.size();
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  samp_valid;
  logic  samp_ready;
  samp_t samp;
  logic  res_valid;
  logic  res_ready;
  res_t  res;

  mean_var_tracker tracker;

  // Sender pacing: when gaps are on, words go out in bursts with idle cycles between.
  bit gaps_on;
  int burst_left;
  int items_sent;

  // Receiver pacing, owned by the receiver process. The main thread only raises
  // hold_req, or asks for a steady receiver that never stalls.
  bit hold_req;
  bit rx_steady;

  integer_mean_and_variance #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .samp_valid(samp_valid),
    .samp_ready(samp_ready),
    .samp      (samp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Inputs only change on the falling edge, so the values seen here at the
  // rising edge are the ones the block sees too.
  always @(posedge clk) begin
    if (!rst) begin
      if (samp_valid && samp_ready) tracker.note_word(samp);
      if (res_valid && res_ready) tracker.check_result(res);
    end
  end

  // Receiver: runs of ready and stalls of random length, with one long hold-off
  // on request. Exactly one assignment to res_ready per falling edge.
  initial begin : receiver
    int run_left;
    int stall_left;
    int hold_left;
    run_left   = 0;
    stall_left = 0;
    hold_left  = 0;
    res_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        if (run_left == 0 && stall_left == 0) begin
          run_left = $urandom_range(1, 12);
          if (rx_steady) stall_left = 0;
          else if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(20, 60);
          else stall_left = $urandom_range(0, 5);
        end
        if (run_left > 0) begin
          run_left--;
          res_ready <= 1'b1;
        end else begin
          stall_left--;
          res_ready <= 1'b0;
        end
      end
    end
  end

  // Offer one word and wait at the rising edges until it is taken. Returns on
  // the next falling edge, where the caller may drive the following word.
  task automatic send_word(input samp_t w);
    samp       <= w;
    samp_valid <= 1'b1;
    @(posedge clk);
    while (!samp_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Send a word, then insert an idle gap when the current burst is used up.
  // An empty gap would drop and raise valid in one step, so it is skipped.
  task automatic offer(input samp_t w);
    int gap;
    send_word(w);
    items_sent++;
    if (gaps_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
        if (gap > 0) begin
          samp_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  endtask

  task automatic send_value(input logic signed [SAMPLE_FIELD_W-1:0] v, input logic is_last);
    samp_t w;
    w.sample = v;
    w.last   = is_last;
    offer(w);
  endtask

  // Mostly full-range values, with the extremes and small values well represented.
  function automatic logic signed [SAMPLE_FIELD_W-1:0] pick_sample();
    int unsigned k;
    logic signed [SAMPLE_FIELD_W-1:0] v;
    k = $urandom_range(0, 15);
    case (k)
      0: v = 16'sh7FFF;
      1: v = 16'sh8000;
      2: v = 16'sh0000;
      3: v = -16'sd1;
      4, 5, 6, 7: v = 16'(int'($urandom_range(0, 16)) - 8);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(9, 40);
    return $urandom_range(1, 8);
  endfunction

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) send_value(pick_sample(), i == len - 1);
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic drain();
    samp_valid <= 1'b0;
    while (tracker.owed() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    tracker    = new();
    rst        = 1'b1;
    samp_valid = 1'b0;
    samp       = '0;
    gaps_on    = 1'b0;
    burst_left = 0;
    items_sent = 0;
    hold_req   = 1'b0;
    rx_steady  = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed sets, sent back to back: single extreme samples, truncation of
    // negative means toward zero, a constant set with zero variance, and the
    // largest spread the sample range allows.
    send_value(16'sh7FFF, 1'b1);
    send_value(16'sh8000, 1'b1);
    send_value(16'sh0000, 1'b1);
    send_value(16'sh8000, 1'b0);
    send_value(16'sh7FFF, 1'b1);
    send_value(-16'sd3, 1'b0);
    send_value(-16'sd4, 1'b1);
    send_value(16'sd5, 1'b0);
    send_value(16'sd6, 1'b0);
    send_value(16'sd8, 1'b1);
    repeat (3) send_value(16'sh8000, 1'b0);
    send_value(16'sh8000, 1'b1);
    send_value(16'sh7FFF, 1'b0);
    send_value(16'sh8000, 1'b0);
    send_value(16'sh7FFF, 1'b0);
    send_value(16'sh8000, 1'b1);
    send_value(16'sd1, 1'b0);
    send_value(16'sd2, 1'b1);
    send_value(-16'sd1, 1'b0);
    send_value(-16'sd2, 1'b0);
    send_value(-16'sd2, 1'b1);
    drain();

    // Random sets with a bursty sender.
    gaps_on = 1'b1;
    while (items_sent < 23 + RANDOM_ITEMS / 3) send_set(pick_len());

    // Long receiver hold-off while the sender keeps offering small sets: the
    // output register and the controller fill and the input must stall.
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (12) send_set($urandom_range(1, 6));
    drain();

    // More random sets: first a receiver that never stalls and a sender without
    // gaps, then both idling again.
    rx_steady = 1'b1;
    repeat (20) send_set(pick_len());
    rx_steady = 1'b0;
    gaps_on   = 1'b1;
    while (items_sent < 23 + RANDOM_ITEMS) send_set(pick_len());

    drain();
    // Any stray result word would show up within the block's latency.
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("tb: %0d sample words taken, %0d result words checked, %0d with overflow",
             tracker.words_taken, tracker.results_checked, tracker.overflow_results);
    $display("tb: %0d mismatches", tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Several times the slowest correct run.
  initial begin : watchdog
    #5000000;
    $display("tb: timeout with %0d results owed", tracker.owed());
    $display("tb: FAIL");
    $finish;
  end

endmodule
